@@ src/mbt_pkg.sv @@
// shared types, codes and constants of the maze backtracker
`timescale 1ns / 1ps
`default_nettype none
package mbt_pkg;

  localparam int MAX_SIDE_DEF = 64;
  localparam int SIDE_RESET   = 16;

  localparam int CFG_DW = 7;
  localparam int CFG_IW = 1;

  localparam logic [CFG_IW-1:0] CFG_MAZE_WIDTH  = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_MAZE_HEIGHT = 1'd1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  localparam logic [3:0] TRIED_NONE = 4'h0;
  localparam logic [3:0] TRIED_ALL  = 4'hF;

  typedef enum logic [2:0] {
    EV_STARTED   = 3'd0,
    EV_CARVED    = 3'd1,
    EV_BLOCKED   = 3'd2,
    EV_BACKTRACK = 3'd3,
    EV_DONE      = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_t;

endpackage
`default_nettype wire

@@ src/mbt_if.sv @@
// input and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface mbt_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [1:0] direction;

  modport source (output valid, output op, output direction, input ready);
  modport sink (input valid, input op, input direction, output ready);
endinterface

interface mbt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [5:0] cell_x;
  logic [5:0] cell_y;
  logic [1:0] wall_dir;
  logic       done_res;

  modport source (output valid, output event_res, output cell_x, output cell_y,
                  output wall_dir, output done_res, input ready);
  modport sink (input valid, input event_res, input cell_x, input cell_y,
                input wall_dir, input done_res, output ready);
endinterface
`default_nettype wire

@@ src/mbt_visit_map.sv @@
// visited map, one row of cells per memory word
`timescale 1ns / 1ps
`default_nettype none
module mbt_visit_map #(
  parameter int MAX_SIDE = mbt_pkg::MAX_SIDE_DEF,
  parameter int XW       = $clog2(MAX_SIDE)
) (
  input  wire logic                clk,
  input  wire logic                rd_en,
  input  wire logic [XW-1:0]       rd_addr,
  output logic      [MAX_SIDE-1:0] rd_row,
  input  wire logic                wr_en,
  input  wire logic [XW-1:0]       wr_addr,
  input  wire logic [MAX_SIDE-1:0] wr_row
);
  import mbt_pkg::*;

  logic [MAX_SIDE-1:0] mem [MAX_SIDE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ src/mbt_path_stack.sv @@
// path stack memory of packed cell coordinates
`timescale 1ns / 1ps
`default_nettype none
module mbt_path_stack #(
  parameter int DEPTH = mbt_pkg::MAX_SIDE_DEF * mbt_pkg::MAX_SIDE_DEF,
  parameter int EW    = 12,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [EW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [EW-1:0] wr_data
);
  import mbt_pkg::*;

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ src/mbt_walker.sv @@
// walker sequencer: reads the memories, decides the step, writes back
`timescale 1ns / 1ps
`default_nettype none
module mbt_walker #(
  parameter int MAX_SIDE = mbt_pkg::MAX_SIDE_DEF,
  parameter int SW       = $clog2(MAX_SIDE + 1),
  parameter int TW       = 2 * SW
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  mbt_in_if.sink             in_ch,
  mbt_out_if.source          out_ch,
  input  wire logic [SW-1:0] side_w,
  input  wire logic [SW-1:0] side_h,
  input  wire logic [TW-1:0] total
);
  import mbt_pkg::*;

  localparam int XW    = $clog2(MAX_SIDE);
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = AW + 1;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int GW    = (CW > TW) ? CW : TW;
  localparam int EW    = 2 * XW;

  state_t state_r, state_nxt;

  logic [XW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          origin_r, origin_nxt;
  logic [PW-1:0] sp_r, sp_nxt;
  logic [XW-1:0] pos_x_r, pos_x_nxt;
  logic [XW-1:0] pos_y_r, pos_y_nxt;
  logic [3:0]    tried_r, tried_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          op_r;
  logic [1:0]    dir_r;

  logic          out_valid_r, out_valid_nxt;
  event_t        ev_r, ev_nxt;
  logic [5:0]    cx_r, cx_nxt;
  logic [5:0]    cy_r, cy_nxt;
  logic [1:0]    wall_r, wall_nxt;
  logic          done_r, done_nxt;

  logic in_fire, out_free, commit, clearing, clr_last;

  logic [XW-1:0]       vis_rd_addr;
  logic [MAX_SIDE-1:0] vis_rd_row;
  logic                vis_we;
  logic [XW-1:0]       vis_wr_addr;
  logic [MAX_SIDE-1:0] vis_wr_row;

  logic [AW-1:0] stk_rd_addr;
  logic [EW-1:0] stk_rd_data;
  logic          stk_we;
  logic [AW-1:0] stk_wr_addr;
  logic [EW-1:0] stk_wr_data;

  logic [SW-1:0] nx_w, ny_w;
  logic          edge_ok, in_grid, seen, is_start, is_carve, stk_full;
  logic [XW-1:0] nx, ny;
  logic [PW-1:0] sp_dec;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign clr_last = clr_cnt_r == XW'(MAX_SIDE - 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = (op_r == OP_START) ? ST_CLEAR : ST_IDLE;
        end
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    commit      = 1'b0;
    clearing    = 1'b0;
    case (state_r)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_EXEC:  commit = out_free;
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // row of the neighbour, fetched as the word is taken
  always_comb begin
    case (in_ch.direction)
      DIR_UP:   vis_rd_addr = pos_y_r - XW'(1);
      DIR_DOWN: vis_rd_addr = pos_y_r + XW'(1);
      default:  vis_rd_addr = pos_y_r;
    endcase
  end

  assign stk_rd_addr = AW'(sp_r - PW'(2));

  // neighbour of the current cell
  always_comb begin
    nx_w    = SW'(pos_x_r);
    ny_w    = SW'(pos_y_r);
    edge_ok = 1'b1;
    case (dir_r)
      DIR_UP: begin
        edge_ok = pos_y_r != '0;
        ny_w    = SW'(pos_y_r) - SW'(1);
      end
      DIR_RIGHT: nx_w = SW'(pos_x_r) + SW'(1);
      DIR_DOWN:  ny_w = SW'(pos_y_r) + SW'(1);
      default: begin
        edge_ok = pos_x_r != '0;
        nx_w    = SW'(pos_x_r) - SW'(1);
      end
    endcase
  end

  assign nx       = nx_w[XW-1:0];
  assign ny       = ny_w[XW-1:0];
  assign in_grid  = edge_ok && (nx_w < side_w) && (ny_w < side_h);
  assign seen     = vis_rd_row[nx];
  assign stk_full = sp_r >= PW'(CELLS);
  assign sp_dec   = (sp_r != '0) ? sp_r - PW'(1) : sp_r;

  // step decision
  always_comb begin
    sp_nxt    = sp_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    tried_nxt = tried_r;
    count_nxt = count_r;
    ev_nxt    = EV_BLOCKED;
    wall_nxt  = DIR_UP;
    is_start  = 1'b0;
    is_carve  = 1'b0;
    if (op_r == OP_START) begin
      is_start  = 1'b1;
      sp_nxt    = PW'(1);
      pos_x_nxt = '0;
      pos_y_nxt = '0;
      tried_nxt = TRIED_NONE;
      count_nxt = CW'(1);
      ev_nxt    = EV_STARTED;
    end else if (GW'(count_r) >= GW'(total)) begin
      ev_nxt = EV_DONE;
    end else if (tried_r == TRIED_ALL) begin
      sp_nxt = sp_dec;
      if (sp_dec != '0) begin
        pos_x_nxt = stk_rd_data[XW-1:0];
        pos_y_nxt = stk_rd_data[EW-1:XW];
      end
      tried_nxt = TRIED_NONE;
      ev_nxt    = EV_BACKTRACK;
    end else if (in_grid && !seen) begin
      is_carve  = 1'b1;
      count_nxt = count_r + CW'(1);
      if (!stk_full) sp_nxt = sp_r + PW'(1);
      pos_x_nxt = nx;
      pos_y_nxt = ny;
      tried_nxt = TRIED_NONE;
      ev_nxt    = EV_CARVED;
      wall_nxt  = dir_r;
    end else begin
      tried_nxt = tried_r | (4'b0001 << dir_r);
    end
  end

  always_comb begin
    if (ev_nxt == EV_CARVED) begin
      cx_nxt = 6'(pos_x_r);
      cy_nxt = 6'(pos_y_r);
    end else begin
      cx_nxt = 6'(pos_x_nxt);
      cy_nxt = 6'(pos_y_nxt);
    end
    done_nxt      = GW'(count_nxt) >= GW'(total);
    out_valid_nxt = commit || (out_valid_r && !out_ch.ready);
    clr_cnt_nxt   = clearing ? clr_cnt_r + XW'(1) : '0;
    origin_nxt    = origin_r || (commit && is_start);
  end

  // memory write-back
  always_comb begin
    vis_we      = clearing || (commit && is_carve);
    vis_wr_addr = clearing ? clr_cnt_r : ny;
    vis_wr_row  = clearing ? MAX_SIDE'(origin_r && clr_cnt_r == '0)
                           : vis_rd_row | (MAX_SIDE'(1) << nx);
    stk_we      = commit && (is_start || (is_carve && !stk_full));
    stk_wr_addr = is_start ? '0 : sp_r[AW-1:0];
    stk_wr_data = is_start ? '0 : {ny, nx};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      origin_r    <= 1'b0;
      sp_r        <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      tried_r     <= TRIED_NONE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      origin_r    <= origin_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        sp_r    <= sp_nxt;
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
        tried_r <= tried_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_ch.op;
      dir_r <= in_ch.direction;
    end
    if (commit) begin
      ev_r   <= ev_nxt;
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      wall_r <= wall_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.event_res = ev_r;
  assign out_ch.cell_x    = cx_r;
  assign out_ch.cell_y    = cy_r;
  assign out_ch.wall_dir  = wall_r;
  assign out_ch.done_res  = done_r;

  mbt_visit_map #(
    .MAX_SIDE (MAX_SIDE),
    .XW       (XW)
  ) u_visit_map (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (vis_rd_addr),
    .rd_row  (vis_rd_row),
    .wr_en   (vis_we),
    .wr_addr (vis_wr_addr),
    .wr_row  (vis_wr_row)
  );

  mbt_path_stack #(
    .DEPTH (CELLS),
    .EW    (EW),
    .AW    (AW)
  ) u_path_stack (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data),
    .wr_en   (stk_we),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data)
  );

  // every stacked cell was counted as visited
  a_sp_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    GW'(sp_r) <= GW'(count_r))
    else $error("stack deeper than visited count");

  a_word_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_EXEC)
    else $error("taken word not executed");

  a_carve_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && is_carve) |=> count_r == $past(count_r) + CW'(1))
    else $error("carve did not count a cell");

  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (!out_valid_r || out_ch.ready))
    else $error("result overwrote a waiting word");

endmodule
`default_nettype wire

@@ src/maze_backtracker_step.sv @@
// maze backtracker top level: size registers and walker
// a taken word moves the walker to its exec state; its result word is registered
//   once the output slot is free. A new word is taken only back in idle, after
//   the read of the visited map and path stack and the write-back
// a start word is followed by a clearing pass of all map rows, one map row a cycle
// reset: synchronous active-low; runs the same clearing pass
`timescale 1ns / 1ps
`default_nettype none
module maze_backtracker_step #(
  parameter int MAX_SIDE = mbt_pkg::MAX_SIDE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mbt_in_if.sink                           in_ch,
  mbt_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [mbt_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [mbt_pkg::CFG_DW-1:0]  cfg_data
);
  import mbt_pkg::*;

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int TW = 2 * SW;
  localparam int DW = (SW > CFG_DW) ? SW : CFG_DW;
  localparam logic [SW-1:0] SIDE_RST =
    (SIDE_RESET > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(SIDE_RESET);

  logic [SW-1:0] side_w_r, side_w_nxt;
  logic [SW-1:0] side_h_r, side_h_nxt;
  logic [DW-1:0] cfg_ext;
  logic [SW-1:0] cfg_side;
  logic [TW-1:0] total;

  // zero acts as one, oversize as the largest side
  always_comb begin
    cfg_ext = DW'(cfg_data);
    if (cfg_ext == '0) begin
      cfg_side = SW'(1);
    end else if (cfg_ext > DW'(MAX_SIDE)) begin
      cfg_side = SW'(MAX_SIDE);
    end else begin
      cfg_side = SW'(cfg_ext);
    end
  end

  always_comb begin
    side_w_nxt = side_w_r;
    side_h_nxt = side_h_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAZE_WIDTH:  side_w_nxt = cfg_side;
        CFG_MAZE_HEIGHT: side_h_nxt = cfg_side;
        default:         side_w_nxt = side_w_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_w_r <= SIDE_RST;
      side_h_r <= SIDE_RST;
    end else begin
      side_w_r <= side_w_nxt;
      side_h_r <= side_h_nxt;
    end
  end

  assign total = TW'(side_w_r) * TW'(side_h_r);

  mbt_walker #(
    .MAX_SIDE (MAX_SIDE),
    .SW       (SW),
    .TW       (TW)
  ) u_walker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .side_w (side_w_r),
    .side_h (side_h_r),
    .total  (total)
  );

endmodule
`default_nettype wire

@@ bench/maze_walk_check.sv @@
// checker: follows both channels and the size registers, predicts each result word and compares
`timescale 1ns / 1ps
module maze_walk_check (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mbt_in_if                                in_ch,
  mbt_out_if                               out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [mbt_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [mbt_pkg::CFG_DW-1:0]  cfg_data,
  output int                               pending,
  output int                               errors
);
  import mbt_pkg::*;

  localparam int SIDE  = MAX_SIDE_DEF;
  localparam int CELLS = SIDE * SIDE;

  typedef struct packed {
    event_t     ev;
    logic [5:0] x;
    logic [5:0] y;
    logic [1:0] wall;
    logic       done;
  } walk_result_t;

  bit           visited_cells [CELLS];
  logic [11:0]  path_cells [CELLS];
  int           path_depth;
  int           walk_x;
  int           walk_y;
  int           visited_total;
  logic [3:0]   tried_dirs;
  logic [6:0]   width_reg;
  logic [6:0]   height_reg;
  walk_result_t expected_walk [$];
  walk_result_t want;
  walk_result_t got;
  int           taken_in = 0;
  int           taken_out = 0;

  initial errors = 0;

  assign pending = taken_in - taken_out;

  function automatic int side_len(logic [6:0] v);
    if (v == 7'd0) begin
      return 1;
    end
    if (int'(v) > SIDE) begin
      return SIDE;
    end
    return int'(v);
  endfunction

  function automatic bit maze_complete();
    return visited_total >= side_len(width_reg) * side_len(height_reg);
  endfunction

  function automatic walk_result_t predict_walk(logic op, logic [1:0] dir);
    walk_result_t r;
    int           nx;
    int           ny;
    bit           in_grid;
    logic [11:0]  top;
    r.wall = 2'd0;
    r.x = 6'(walk_x);
    r.y = 6'(walk_y);
    if (op == OP_START) begin
      foreach (visited_cells[i]) visited_cells[i] = 1'b0;
      walk_x = 0;
      walk_y = 0;
      tried_dirs = TRIED_NONE;
      visited_cells[0] = 1'b1;
      visited_total = 1;
      path_cells[0] = 12'd0;
      path_depth = 1;
      r.ev = EV_STARTED;
    end else if (maze_complete()) begin
      r.ev = EV_DONE;
    end else if (tried_dirs == TRIED_ALL) begin
      // dead end: drop the current cell and go back to the one beneath it
      if (path_depth > 0) path_depth--;
      if (path_depth > 0) begin
        top = path_cells[path_depth - 1];
        walk_x = int'(top) % SIDE;
        walk_y = int'(top) / SIDE;
      end
      tried_dirs = TRIED_NONE;
      r.ev = EV_BACKTRACK;
    end else begin
      nx = walk_x;
      ny = walk_y;
      in_grid = 1'b1;
      case (dir)
        DIR_UP: begin
          in_grid = walk_y > 0;
          if (in_grid) ny = walk_y - 1;
        end
        DIR_RIGHT: nx = walk_x + 1;
        DIR_DOWN: ny = walk_y + 1;
        default: begin
          in_grid = walk_x > 0;
          if (in_grid) nx = walk_x - 1;
        end
      endcase
      in_grid = in_grid && nx < side_len(width_reg) && ny < side_len(height_reg);
      if (in_grid && !visited_cells[ny * SIDE + nx]) begin
        r.ev = EV_CARVED;
        r.wall = dir;
        visited_cells[ny * SIDE + nx] = 1'b1;
        visited_total++;
        if (path_depth < CELLS) begin
          path_cells[path_depth] = 12'(ny * SIDE + nx);
          path_depth++;
        end
        walk_x = nx;
        walk_y = ny;
        tried_dirs = TRIED_NONE;
      end else begin
        tried_dirs = tried_dirs | (4'b0001 << dir);
        r.ev = EV_BLOCKED;
      end
    end
    if (r.ev != EV_CARVED) begin
      r.x = 6'(walk_x);
      r.y = 6'(walk_y);
    end
    r.done = maze_complete();
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (visited_cells[i]) visited_cells[i] = 1'b0;
      path_depth = 0;
      walk_x = 0;
      walk_y = 0;
      visited_total = 0;
      tried_dirs = TRIED_NONE;
      width_reg = 7'(SIDE_RESET);
      height_reg = 7'(SIDE_RESET);
      expected_walk.delete();
      taken_in <= 0;
      taken_out <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        taken_out <= taken_out + 1;
        got = {out_ch.event_res, out_ch.cell_x, out_ch.cell_y, out_ch.wall_dir,
               out_ch.done_res};
        if (expected_walk.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: result word with none outstanding: ev %0d x %0d y %0d wall %0d done %0d",
                     $realtime, got.ev, got.x, got.y, got.wall, got.done);
          end
          errors++;
        end else begin
          want = expected_walk.pop_front();
          if (got !== want) begin
            if (errors < 10) begin
              $display("%0t: mismatch ev %0d/%0d x %0d/%0d y %0d/%0d wall %0d/%0d done %0d/%0d",
                       $realtime, want.ev, got.ev, want.x, got.x, want.y, got.y,
                       want.wall, got.wall, want.done, got.done);
              $display("  (expected/actual)");
            end
            errors++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_MAZE_WIDTH) width_reg = cfg_data;
        else if (cfg_index == CFG_MAZE_HEIGHT) height_reg = cfg_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_walk.insert(expected_walk.size(), predict_walk(in_ch.op, in_ch.direction));
        taken_in <= taken_in + 1;
      end
    end
  end

endmodule

@@ bench/tb.sv @@
// testbench top: clock, reset, size writes, start and step words, output stalls and verdict
`timescale 1ns / 1ps
module tb;
  import mbt_pkg::*;

  localparam int SETTLE_CYCLES = MAX_SIDE_DEF + 16;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int RANDOM_WORDS  = 700;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IW-1:0]    cfg_index;
  logic [CFG_DW-1:0]    cfg_data;
  int                   pending_words;
  int                   failures;
  int                   cycle_count = 0;
  bit                   no_gaps = 1'b0;

  mbt_in_if  in_ch ();
  mbt_out_if out_ch ();

  maze_backtracker_step u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  maze_walk_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending_words),
    .errors    (failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [6:0] pick_side();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 7'd0;
    if (r < 14) return 7'd64;
    if (r < 20) return 7'($urandom_range(65, 127));
    if (r < 24) return 7'd127;
    if (r < 34) return 7'd1;
    if (r < 75) return 7'($urandom_range(2, 5));
    return 7'($urandom_range(6, 16));
  endfunction

  task automatic send_word(input logic op, input logic [1:0] dir);
    int gap;
    gap = no_gaps ? 0 : gap_len();
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.direction <= dir;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_size(input logic [6:0] w, input logic [6:0] h);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAZE_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_MAZE_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for every result word, then let any clearing pass run out
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int run;
    int stall;
    out_ch.ready <= 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      repeat (run) begin
        @(posedge clk);
        out_ch.ready <= 1'b1;
      end
      stall = gap_len();
      repeat (stall) begin
        @(posedge clk);
        out_ch.ready <= 1'b0;
      end
    end
  end

  initial begin
    int         random_words;
    int         phase_no;
    int         phase_len;
    logic [1:0] lean;
    logic [6:0] w;
    logic [6:0] h;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_START;
    in_ch.direction <= DIR_UP;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MAZE_WIDTH;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // one-cell grid before a start: all blocked, empty-stack backtrack, start, done step
    write_size(7'd0, 7'd0);
    send_word(OP_STEP, DIR_UP);
    send_word(OP_STEP, DIR_RIGHT);
    send_word(OP_STEP, DIR_DOWN);
    send_word(OP_STEP, DIR_LEFT);
    send_word(OP_STEP, DIR_DOWN);
    send_word(OP_START, DIR_LEFT);
    send_word(OP_STEP, DIR_RIGHT);
    settle();

    // three by two: carve into a dead end, back out, finish, then a step when done
    write_size(7'd3, 7'd2);
    send_word(OP_START, DIR_UP);
    send_word(OP_STEP, DIR_RIGHT);
    send_word(OP_STEP, DIR_DOWN);
    send_word(OP_STEP, DIR_LEFT);
    send_word(OP_STEP, DIR_UP);
    send_word(OP_STEP, DIR_RIGHT);
    send_word(OP_STEP, DIR_DOWN);
    send_word(OP_STEP, DIR_LEFT);
    send_word(OP_STEP, DIR_UP);
    send_word(OP_STEP, DIR_RIGHT);
    send_word(OP_STEP, DIR_UP);
    send_word(OP_STEP, DIR_LEFT);
    settle();

    // oversized registers clamp to the largest grid
    write_size(7'd127, 7'd65);
    send_word(OP_START, DIR_RIGHT);
    send_word(OP_STEP, DIR_LEFT);
    send_word(OP_STEP, DIR_UP);
    send_word(OP_STEP, DIR_DOWN);
    settle();

    // shrink mid-maze so the walker sits outside the grid
    write_size(7'd1, 7'd1);
    send_word(OP_STEP, DIR_RIGHT);

    random_words = 0;
    phase_no = 0;
    while (random_words < RANDOM_WORDS) begin
      settle();
      if (phase_no < 2 || $urandom_range(0, 99) < 12) begin
        // long corridors reach the far row and column
        if (phase_no == 0 || (phase_no > 1 && $urandom_range(0, 1) == 1)) begin
          w = 7'd64;
          h = 7'($urandom_range(1, 2));
          lean = DIR_RIGHT;
        end else begin
          w = 7'($urandom_range(1, 2));
          h = 7'd64;
          lean = DIR_DOWN;
        end
        phase_len = 140;
      end else begin
        w = pick_side();
        h = pick_side();
        lean = 2'($urandom_range(0, 3));
        phase_len = $urandom_range(10, 60);
      end
      write_size(w, h);
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 85) begin
        send_word(OP_START, 2'($urandom_range(0, 3)));
        random_words++;
      end
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < 3) begin
          send_word(OP_START, 2'($urandom_range(0, 3)));
        end else if ($urandom_range(0, 99) < 60) begin
          send_word(OP_STEP, lean);
        end else begin
          send_word(OP_STEP, 2'($urandom_range(0, 3)));
        end
        random_words++;
      end
      phase_no++;
    end

    settle();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/mbt_pkg.sv
src/mbt_if.sv
src/mbt_visit_map.sv
src/mbt_path_stack.sv
src/mbt_walker.sv
src/maze_backtracker_step.sv
bench/maze_walk_check.sv
bench/tb.sv
